// ===== hdl/abbb_pkg.sv =====
// Package for the alpha bitmap bounding box block: operation codes, beat layouts
// and default sizes. It has no dependencies, and the top level and its checker import it.
`default_nettype none

package abbb_pkg;

    localparam int MAX_DIM_DEFAULT = 8192;

    localparam int OP_W     = 2;
    localparam int COORD_W  = 14;
    localparam int DIM_W    = 13;
    localparam int ALPHA_W  = 8;
    localparam int EDGE_W   = 16;
    localparam int RPOS_W   = 15;
    localparam int RSIZE_W  = 16;
    localparam int IN_W     = 64;
    localparam int OUT_W    = 64;

    typedef enum logic [OP_W-1:0] {
        OP_HEADER = 2'd0,
        OP_PIXEL  = 2'd1,
        OP_END    = 2'd2,
        OP_REPEAT = 2'd3
    } t_op;

    // Input beat payload; the first member listed sits in the highest bits.
    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic               first_image;
        logic               skip_image;
        logic [DIM_W-1:0]   image_height;
        logic [DIM_W-1:0]   image_width;
        logic [COORD_W-1:0] image_y;
        logic [COORD_W-1:0] image_x;
    } t_in_beat;

    // Rectangle as it leaves on the output stream.
    typedef struct packed {
        logic [RSIZE_W-1:0] rect_h;
        logic [RSIZE_W-1:0] rect_w;
        logic [RPOS_W-1:0]  rect_y;
        logic [RPOS_W-1:0]  rect_x;
    } t_rect;

endpackage

`default_nettype wire

// ===== hdl/alpha_bitmap_bounding_box.sv =====
// Top level of the alpha bitmap bounding box: the input register, the edge tracking
// logic and the output register. It depends on abbb_pkg.
`default_nettype none

//  Channel  Direction  Ports                          Contents
//  s        in         i_s_tvalid/o_s_tready          header, pixel, end of frame, repeat
//  m        out        o_m_tvalid/i_m_tready          bounding rectangle x, y, w, h
//
// One beat is accepted per cycle. A beat first lands in the input register, and
// in the next cycle it updates the edge registers. End of frame and repeat load
// the output register, which then offers the rectangle. The
// input register stalls only when it holds an end of frame or a repeat beat while
// the output register still holds a rectangle that has not been taken. Header and
// pixel beats keep flowing while a result waits. The reset is synchronous and
// active low: it clears the edges, counters, the current image and the kept
// rectangle, and it holds o_s_tready low.
module alpha_bitmap_bounding_box #(
    parameter int MAX_DIM = abbb_pkg::MAX_DIM_DEFAULT
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_tvalid,
    output logic                           o_s_tready,
    // From bit 0: image_x[13:0], image_y[27:14], image_width[40:28],
    // image_height[53:41], skip_image[54], first_image[55], alpha[63:56].
    input  wire logic [abbb_pkg::IN_W-1:0] i_s_tdata,
    // From bit 0: op[1:0].
    input  wire logic [abbb_pkg::OP_W-1:0] i_s_tuser,
    output logic                           o_m_tvalid,
    input  wire logic                      i_m_tready,
    // From bit 0: rect_x[14:0], rect_y[29:15], rect_w[45:30], rect_h[61:46],
    // zero fill[63:62].
    output logic [abbb_pkg::OUT_W-1:0]     o_m_tdata
);
    import abbb_pkg::*;

    // Counters hold the positions 0 to MAX_DIM-1. The incremented value needs
    // one more bit so that it can reach MAX_DIM itself.
    localparam int CW   = $clog2(MAX_DIM);
    localparam int CW1  = CW + 1;
    localparam int CMPW = (CW1 > DIM_W) ? CW1 : DIM_W;
    localparam logic [CW1-1:0] MAX_CNT = CW1'(MAX_DIM);

    // Input register.
    logic                 r_in_valid;
    t_op                  r_op;
    t_in_beat             r_in;

    // Edge tracking state.
    logic [EDGE_W-1:0]    r_left, r_top, r_right, r_bottom;
    logic [EDGE_W-1:0]    n_left, n_top, n_right, n_bottom;
    logic [CW-1:0]        r_col, r_row, n_col, n_row;
    logic                 r_row_painted, n_row_painted;
    logic [COORD_W-1:0]   r_cur_x, r_cur_y, n_cur_x, n_cur_y;
    logic [DIM_W-1:0]     r_cur_w, n_cur_w;
    logic                 r_cur_skip, n_cur_skip;
    t_rect                r_last, n_last;

    logic                 r_out_valid;

    logic                 has_result;
    logic                 advance;
    logic [EDGE_W-1:0]    pix_x, pix_y;
    logic [CW1-1:0]       col_inc, row_inc;
    logic                 row_done;
    logic                 painted;

    // A beat leaves the input register unless it makes a result and the
    // output register cannot take it in this cycle.
    assign has_result = (r_op == OP_END) || (r_op == OP_REPEAT);
    assign advance    = r_in_valid && (!has_result || !r_out_valid || i_m_tready);
    assign o_s_tready = i_rst_n && (!r_in_valid || advance);

    // Frame positions are one-based: a painted pixel at column c moves the
    // right edge to c+1 and the left edge to c.
    assign pix_x    = EDGE_W'(r_cur_x) + EDGE_W'(r_col) + EDGE_W'(1);
    assign pix_y    = EDGE_W'(r_cur_y) + EDGE_W'(r_row) + EDGE_W'(1);
    assign col_inc  = CW1'(r_col) + CW1'(1);
    assign row_inc  = CW1'(r_row) + CW1'(1);
    // A row ends at the image width or at MAX_DIM. A zero width ends every row
    // at once.
    assign row_done = (CMPW'(col_inc) >= CMPW'(r_cur_w)) || (col_inc >= MAX_CNT);
    assign painted  = (r_in.alpha != '0) && !r_cur_skip;

    always_comb begin
        n_left        = r_left;
        n_top         = r_top;
        n_right       = r_right;
        n_bottom      = r_bottom;
        n_col         = r_col;
        n_row         = r_row;
        n_row_painted = r_row_painted;
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_cur_w       = r_cur_w;
        n_cur_skip    = r_cur_skip;
        n_last        = r_last;
        if (advance) begin
            unique case (r_op)
                OP_HEADER: begin
                    n_cur_x    = r_in.image_x;
                    n_cur_y    = r_in.image_y;
                    n_cur_w    = r_in.image_width;
                    n_cur_skip = r_in.skip_image;
                    // The first image of a frame starts the bounds inverted so
                    // that the first painted pixel inside the image sets every edge.
                    if (r_in.first_image) begin
                        n_left   = EDGE_W'(r_in.image_x) + EDGE_W'(r_in.image_width);
                        n_top    = EDGE_W'(r_in.image_y) + EDGE_W'(r_in.image_height);
                        n_right  = '0;
                        n_bottom = '0;
                    end
                    n_col         = '0;
                    n_row         = '0;
                    n_row_painted = 1'b0;
                end
                OP_PIXEL: begin
                    if (painted) begin
                        if (pix_x <= r_left) begin
                            n_left = pix_x - EDGE_W'(1);
                        end
                        if (pix_x > r_right) begin
                            n_right = pix_x;
                        end
                        // The top and bottom edges move once per row at most.
                        if (!r_row_painted) begin
                            if (pix_y <= r_top) begin
                                n_top = pix_y - EDGE_W'(1);
                            end
                            if (pix_y > r_bottom) begin
                                n_bottom = pix_y;
                            end
                            n_row_painted = 1'b1;
                        end
                    end
                    if (row_done) begin
                        n_col         = '0;
                        n_row_painted = 1'b0;
                        n_row         = (row_inc >= MAX_CNT) ? '0 : row_inc[CW-1:0];
                    end else begin
                        n_col = col_inc[CW-1:0];
                    end
                end
                OP_END: begin
                    n_last.rect_x = r_left[RPOS_W-1:0];
                    n_last.rect_y = r_top[RPOS_W-1:0];
                    n_last.rect_w = r_right - r_left;
                    n_last.rect_h = r_bottom - r_top;
                end
                OP_REPEAT: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_left        <= '0;
            r_top         <= '0;
            r_right       <= '0;
            r_bottom      <= '0;
            r_col         <= '0;
            r_row         <= '0;
            r_row_painted <= 1'b0;
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_cur_w       <= '0;
            r_cur_skip    <= 1'b0;
            r_last        <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance && has_result) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            r_left        <= n_left;
            r_top         <= n_top;
            r_right       <= n_right;
            r_bottom      <= n_bottom;
            r_col         <= n_col;
            r_row         <= n_row;
            r_row_painted <= n_row_painted;
            r_cur_x       <= n_cur_x;
            r_cur_y       <= n_cur_y;
            r_cur_w       <= n_cur_w;
            r_cur_skip    <= n_cur_skip;
            r_last        <= n_last;
        end
    end

    // The input payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_op <= t_op'(i_s_tuser);
            r_in <= t_in_beat'(i_s_tdata);
        end
    end

    // The kept rectangle changes only when an end of frame beat loads the output
    // register, which is free at that moment. It therefore serves as the output
    // payload for both end of frame and repeat beats.
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'(r_last);

endmodule

`default_nettype wire

// ===== hdl/abbb_checker.sv =====
// Port-level assertions for alpha_bitmap_bounding_box and the bind that attaches
// them. It depends on abbb_pkg and on the top level's port names.
`default_nettype none

module abbb_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_tvalid,
    input  wire logic                      o_s_tready,
    input  wire logic [abbb_pkg::OP_W-1:0] i_s_tuser,
    input  wire logic                      o_m_tvalid,
    input  wire logic                      i_m_tready,
    input  wire logic [abbb_pkg::OUT_W-1:0] o_m_tdata
);
    import abbb_pkg::*;

    logic s_acc;
    assign s_acc = i_s_tvalid && o_s_tready;

    // A result offered to an empty output comes from the beat that was accepted,
    // went through the input register without a stall and asked for a result.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(s_acc, 2) && $past(i_s_tuser[1], 2)))
        else $error("result appeared without a matching end of frame or repeat beat");

    // The input is closed while reset is held, and the output is empty after
    // any reset edge.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |-> (!o_s_tready ##1 !o_m_tvalid))
        else $error("input ready high in reset or output valid after a reset edge");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("result withdrawn before it was taken");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> $stable(o_m_tdata))
        else $error("result changed while stalled");

endmodule

bind alpha_bitmap_bounding_box abbb_checker u_abbb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for alpha_bitmap_bounding_box: a directed table and random
// frames, with a bounding-box predictor and a rectangle scoreboard. Needs only abbb_pkg
// and the block's top level.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import abbb_pkg::*;

    // Random beats after the directed table; the last stretch runs without idling.
    localparam int ITEMS       = 420;
    localparam int CALM_ITEMS  = 60;
    // Long receiver hold-off, in cycles, while the sender keeps offering beats.
    localparam int HOLD_CYCLES = 300;
    // Cycles without any accepted beat on either side before the run is declared hung.
    localparam int STALL_LIMIT = 3000;
    // Idle cycles after the last owed rectangle has arrived, to cover the tail.
    localparam int DRAIN_CYCLES = 8;

    // One row of the directed table. When known is set, the rectangle is typed in
    // by hand and goes to the scoreboard in place of the predicted one.
    typedef struct {
        t_op      op;
        t_in_beat fields;
        bit       known;
        t_rect    rect;
    } t_step;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [IN_W-1:0]      i_s_tdata;
    logic [OP_W-1:0]      i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [OUT_W-1:0]     o_m_tdata;

    alpha_bitmap_bounding_box dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Rectangles the block still owes us, oldest first.
    t_rect pending_rects[$];
    int    mismatches   = 0;
    int    random_items = 0;
    // Set near the end of the run: neither side inserts idle cycles any more.
    bit    calm         = 0;
    // Cycles the receiver still has to hold off; loaded by the sender, counted down
    // by the receiver.
    int    rx_hold      = 0;

    // Predictor state: edges of the running box, scan position inside the current
    // image, the current image itself, and the rectangle kept for repeats.
    int    left_e, top_e, right_e, bottom_e;
    int    col_pos, row_pos;
    bit    row_hit;
    int    img_x, img_y, img_w;
    bit    img_skip;
    t_rect kept_rect;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Advances the bounding-box state by one accepted beat. Edges are kept 1-based:
    // a painted pixel at column c pulls the left edge to c and pushes the right edge
    // to c+1; rows do the same for top and bottom, once per image row.
    function automatic void track_bounds(input t_op op, input t_in_beat f,
                                         output bit emits, output t_rect rect);
        int          px;
        int          py;
        logic [15:0] span_w;
        logic [15:0] span_h;
        emits = 1'b0;
        rect  = '0;
        case (op)
            OP_HEADER: begin
                img_x    = int'(f.image_x);
                img_y    = int'(f.image_y);
                img_w    = int'(f.image_width);
                img_skip = f.skip_image;
                // The first image of a frame starts the box inside out, so that
                // the first painted pixel inside the image pulls every edge.
                if (f.first_image) begin
                    left_e   = img_x + img_w;
                    top_e    = img_y + int'(f.image_height);
                    right_e  = 0;
                    bottom_e = 0;
                end
                col_pos = 0;
                row_pos = 0;
                row_hit = 1'b0;
            end
            OP_PIXEL: begin
                if (f.alpha != 8'd0 && !img_skip) begin
                    px = img_x + col_pos + 1;
                    if (px <= left_e) left_e = px - 1;
                    if (px > right_e) right_e = px;
                    if (!row_hit) begin
                        py = img_y + row_pos + 1;
                        if (py <= top_e) top_e = py - 1;
                        if (py > bottom_e) bottom_e = py;
                        row_hit = 1'b1;
                    end
                end
                // A row ends at the image width; a zero width makes every byte a
                // row. The row count wraps at the largest size the block handles.
                col_pos++;
                if (col_pos >= img_w || col_pos >= MAX_DIM_DEFAULT) begin
                    col_pos = 0;
                    row_hit = 1'b0;
                    row_pos++;
                    if (row_pos >= MAX_DIM_DEFAULT) row_pos = 0;
                end
            end
            OP_END: begin
                // Width and height wrap at 16 bits, so an unpainted frame comes out
                // negative. The edges stay as they are for the next frame.
                span_w = 16'(right_e - left_e);
                span_h = 16'(bottom_e - top_e);
                kept_rect.rect_x = left_e[RPOS_W-1:0];
                kept_rect.rect_y = top_e[RPOS_W-1:0];
                kept_rect.rect_w = span_w;
                kept_rect.rect_h = span_h;
                emits = 1'b1;
                rect  = kept_rect;
            end
            default: begin
                emits = 1'b1;
                rect  = kept_rect;
            end
        endcase
    endfunction

    // Offers one beat, at times after a random idle burst unless the run is calm, and
    // waits until the block takes it. The predictor runs on the accepted beat.
    task automatic send_beat(input t_op op, input t_in_beat f,
                             input bit known = 1'b0, input t_rect want = '0);
        int    gap;
        bit    emits;
        t_rect rect;
        if (!calm && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 14);
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= f;
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        track_bounds(op, f, emits, rect);
        if (emits) pending_rects.push_back(known ? want : rect);
    endtask

    // Table row checked against the predictor.
    function automatic t_step plain(input t_op op, input int x, input int y, input int w,
                                    input int h, input bit sk, input bit fi, input int a);
        t_step s;
        s.op                  = op;
        s.fields.image_x      = COORD_W'(x);
        s.fields.image_y      = COORD_W'(y);
        s.fields.image_width  = DIM_W'(w);
        s.fields.image_height = DIM_W'(h);
        s.fields.skip_image   = sk;
        s.fields.first_image  = fi;
        s.fields.alpha        = ALPHA_W'(a);
        s.known               = 1'b0;
        s.rect                = '0;
        return s;
    endfunction

    // Table row whose rectangle is typed in by hand.
    function automatic t_step known_rect(input t_op op, input int rx, input int ry,
                                         input int rw, input int rh);
        t_step s;
        s             = plain(op, 0, 0, 0, 0, 1'b0, 1'b0, 0);
        s.known       = 1'b1;
        s.rect.rect_x = RPOS_W'(rx);
        s.rect.rect_y = RPOS_W'(ry);
        s.rect.rect_w = RSIZE_W'(rw);
        s.rect.rect_h = RSIZE_W'(rh);
        return s;
    endfunction

    // One random frame: mostly well-formed header and pixel sequences with random
    // placement and content, sometimes short or long by a few bytes, and now and
    // then a burst of beats with arbitrary codes and fields.
    task automatic random_frame();
        t_in_beat f;
        int       n_img;
        int       n_pix;
        if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                f = {$urandom, $urandom};
                send_beat(t_op'($urandom_range(0, 3)), f);
                random_items++;
            end
        end else begin
            n_img = $urandom_range(1, 3);
            for (int i = 0; i < n_img; i++) begin
                f = {$urandom, $urandom};
                if ($urandom_range(0, 1)) begin
                    f.image_x = COORD_W'($urandom_range(0, 40));
                    f.image_y = COORD_W'($urandom_range(0, 40));
                end
                // Mostly small images; a few declare huge sizes and get only a
                // handful of bytes.
                if ($urandom_range(0, 9) != 0) begin
                    f.image_width  = DIM_W'($urandom_range(0, 10));
                    f.image_height = DIM_W'($urandom_range(0, 6));
                end
                f.skip_image  = ($urandom_range(0, 6) == 0);
                f.first_image = (i == 0) ? ($urandom_range(0, 9) != 0)
                                         : ($urandom_range(0, 9) == 0);
                send_beat(OP_HEADER, f);
                random_items++;
                n_pix = (f.image_width == 0) ? int'(f.image_height)
                                             : int'(f.image_width) * int'(f.image_height);
                if (n_pix > 30) n_pix = $urandom_range(1, 30);
                if ($urandom_range(0, 7) == 0) n_pix = n_pix + $urandom_range(0, 4) - 2;
                if (n_pix < 0) n_pix = 0;
                repeat (n_pix) begin
                    f = {$urandom, $urandom};
                    f.alpha = $urandom_range(0, 1) ? 8'($urandom_range(1, 255)) : 8'd0;
                    send_beat(OP_PIXEL, f);
                    random_items++;
                end
            end
            f = {$urandom, $urandom};
            send_beat(OP_END, f);
            random_items++;
            if ($urandom_range(0, 4) == 0) begin
                f = {$urandom, $urandom};
                send_beat(OP_REPEAT, f);
                random_items++;
            end
        end
    endtask

    // Receiver: samples the result stream at the rising edge and drives its ready at
    // the falling edge, with random stall bursts and one long hold-off on request.
    initial begin
        int    stall;
        t_rect got;
        t_rect want;
        stall      = 0;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata[$bits(t_rect)-1:0];
                if (pending_rects.size() == 0) begin
                    flag_mismatch($sformatf("unexpected rectangle x=%0d y=%0d w=%0d h=%0d",
                        got.rect_x, got.rect_y, $signed(got.rect_w), $signed(got.rect_h)));
                end else begin
                    want = pending_rects.pop_front();
                    if (got.rect_x !== want.rect_x)
                        flag_mismatch($sformatf("rect_x %0d, expected %0d",
                                                got.rect_x, want.rect_x));
                    if (got.rect_y !== want.rect_y)
                        flag_mismatch($sformatf("rect_y %0d, expected %0d",
                                                got.rect_y, want.rect_y));
                    if (got.rect_w !== want.rect_w)
                        flag_mismatch($sformatf("rect_w %0d, expected %0d",
                                                $signed(got.rect_w), $signed(want.rect_w)));
                    if (got.rect_h !== want.rect_h)
                        flag_mismatch($sformatf("rect_h %0d, expected %0d",
                                                $signed(got.rect_h), $signed(want.rect_h)));
                end
            end
            @(negedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
                i_m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                stall = $urandom_range(1, 14) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: a run in which nothing moves on either side for too long is hung.
    initial begin
        int still;
        still = 0;
        wait (i_rst_n === 1'b1);
        while (still < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) still = 0;
            else still++;
        end
        $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Sender and sequencing of the whole run.
    initial begin
        t_step    steps[$];
        bit       held;
        bit       paused;
        held       = 1'b0;
        paused     = 1'b0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = OP_HEADER;
        left_e     = 0;
        top_e      = 0;
        right_e    = 0;
        bottom_e   = 0;
        col_pos    = 0;
        row_pos    = 0;
        row_hit    = 1'b0;
        img_x      = 0;
        img_y      = 0;
        img_w      = 0;
        img_skip   = 1'b0;
        kept_rect  = '0;

        // Directed table. Straight out of reset the kept rectangle and the edges
        // are all zero. Pixel bytes before any header land on the reset image at
        // the origin with zero width, so each byte is a row of its own.
        steps.push_back(known_rect(OP_REPEAT, 0, 0, 0, 0));
        steps.push_back(known_rect(OP_END, 0, 0, 0, 0));
        steps.push_back(plain(OP_PIXEL, 16383, 16383, 8191, 8191, 1'b1, 1'b1, 8'h80));
        steps.push_back(plain(OP_PIXEL, 0, 0, 0, 0, 1'b0, 1'b0, 8'h00));
        steps.push_back(known_rect(OP_END, 0, 0, 1, 1));
        // Largest placement and size with nothing painted: the box stays inside out.
        steps.push_back(plain(OP_HEADER, 16383, 16383, 8191, 8191, 1'b0, 1'b1, 8'hFF));
        steps.push_back(known_rect(OP_END, 24574, 24574, -24574, -24574));
        // A small image with a stray byte past its last row, then a skipped image
        // and a zero-width image that add to the same box.
        steps.push_back(plain(OP_HEADER, 5, 3, 3, 2, 1'b0, 1'b1, 8'h00));
        steps.push_back(plain(OP_PIXEL, 0, 0, 0, 0, 1'b0, 1'b0, 8'h00));
        steps.push_back(plain(OP_PIXEL, 0, 0, 0, 0, 1'b0, 1'b0, 8'hFF));
        steps.push_back(plain(OP_PIXEL, 0, 0, 0, 0, 1'b0, 1'b0, 8'h00));
        steps.push_back(plain(OP_PIXEL, 0, 0, 0, 0, 1'b0, 1'b0, 8'h01));
        steps.push_back(plain(OP_PIXEL, 0, 0, 0, 0, 1'b0, 1'b0, 8'h00));
        steps.push_back(plain(OP_PIXEL, 0, 0, 0, 0, 1'b0, 1'b0, 8'hFF));
        steps.push_back(plain(OP_PIXEL, 0, 0, 0, 0, 1'b0, 1'b0, 8'h40));
        steps.push_back(plain(OP_HEADER, 0, 0, 2, 1, 1'b1, 1'b0, 8'h00));
        steps.push_back(plain(OP_PIXEL, 0, 0, 0, 0, 1'b0, 1'b0, 8'hFF));
        steps.push_back(plain(OP_PIXEL, 0, 0, 0, 0, 1'b0, 1'b0, 8'hFF));
        steps.push_back(plain(OP_HEADER, 100, 50, 0, 8191, 1'b0, 1'b0, 8'h00));
        steps.push_back(plain(OP_PIXEL, 0, 0, 0, 0, 1'b0, 1'b0, 8'h10));
        steps.push_back(plain(OP_PIXEL, 0, 0, 0, 0, 1'b0, 1'b0, 8'h10));
        steps.push_back(plain(OP_END, 0, 0, 0, 0, 1'b0, 1'b0, 8'h00));
        steps.push_back(plain(OP_REPEAT, 16383, 16383, 8191, 8191, 1'b1, 1'b1, 8'hFF));
        // A skipped first image still starts the box.
        steps.push_back(plain(OP_HEADER, 0, 0, 8191, 0, 1'b1, 1'b1, 8'h00));
        steps.push_back(known_rect(OP_END, 8191, 0, -8191, 0));

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (steps[i]) send_beat(steps[i].op, steps[i].fields, steps[i].known,
                                     steps[i].rect);

        while (random_items < ITEMS) begin
            calm = (random_items >= ITEMS - CALM_ITEMS);
            // The receiver stops for a long stretch while frames keep coming, so the
            // output register fills and the block has to stall its input.
            if (!held && random_items >= 120) begin
                held    = 1'b1;
                rx_hold = HOLD_CYCLES;
            end
            // The sender goes quiet until every rectangle owed has arrived.
            if (!paused && random_items >= 330) begin
                paused = 1'b1;
                @(negedge i_clk);
                i_s_tvalid <= 1'b0;
                while (pending_rects.size() != 0) @(posedge i_clk);
            end
            random_frame();
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_rects.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/abbb_pkg.sv
hdl/alpha_bitmap_bounding_box.sv
hdl/abbb_checker.sv
dv/tb.sv
